// ===== sv/i2csm_pkg.sv =====
// Package for the I2C sensor master core: command codes, bus phases,
// widths of the stream payloads and burst geometry. No dependencies.
package i2csm_pkg;

    localparam int BURST_BYTES   = 6;
    localparam int CAPTURE_BYTES = 6;
    localparam int CAPTURE_W     = CAPTURE_BYTES * 8;
    localparam int SAMPLE_W      = 18;
    localparam int IN_W          = 24;
    localparam int OUT_W         = 56;
    localparam int CFG_DATA_W    = 8;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_BURST = 2'd3
    } cmd_t;

    typedef enum logic {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_FIFO_REGISTER  = 1'b1
    } cfg_index_t;

    // Byte stages of a transfer, kept in byte_count while sending.
    localparam logic [2:0] STAGE_DEV_W  = 3'd0;
    localparam logic [2:0] STAGE_REG    = 3'd1;
    localparam logic [2:0] STAGE_DATA   = 3'd2;
    localparam logic [2:0] STAGE_DEV_R  = 3'd3;

    typedef enum logic [16:0] {
        PH_IDLE       = 17'h00001,
        PH_START_LOW  = 17'h00002,
        PH_TX_LOW     = 17'h00004,
        PH_TX_HIGH    = 17'h00008,
        PH_ACK_LOW    = 17'h00010,
        PH_ACK_HIGH   = 17'h00020,
        PH_RS_LOW     = 17'h00040,
        PH_RS_HIGH    = 17'h00080,
        PH_RS_FALL    = 17'h00100,
        PH_RS_CLAMP   = 17'h00200,
        PH_RX_LOW     = 17'h00400,
        PH_RX_HIGH    = 17'h00800,
        PH_MACK_LOW   = 17'h01000,
        PH_MACK_HIGH  = 17'h02000,
        PH_STOP_LOW   = 17'h04000,
        PH_STOP_HIGH  = 17'h08000,
        PH_STOP_END   = 17'h10000
    } phase_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ir_sample;
        logic [SAMPLE_W-1:0] red_sample;
        logic [7:0]          read_byte;
        logic                ok;
        logic                done_res;
        logic                busy_res;
        logic                sda_oe;
        logic                sda_out;
        logic                scl;
    } result_t;

endpackage

// ===== sv/i2c_sensor_master_fsm_core.sv =====
// Top level of the I2C sensor master: tick-driven bus sequencer with a
// result register and skid stage on the output stream. Uses i2csm_pkg.
//
// channel   | dir | handshake                   | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tuser opcode, tdata tick fields
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata line levels, status, samples
// cfg       | in  | cfg_we (no wait)            | cfg_index, cfg_data
//
// One tick per cycle while s_axis_tready is high: the next bus state is
// formed in one pass of logic and registered together with the result. A
// result waiting on m_axis goes to the skid stage while one more tick is
// taken; s_axis_tready drops only when the skid stage is full. Reset leaves
// the bus idle (SCL and SDA high, driven).
module i2c_sensor_master_fsm_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] reg_addr, [15:8] write_data, [16] sda_level, [23:17] zero
    input  logic [i2csm_pkg::IN_W-1:0]        s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] scl, [1] sda_out, [2] sda_oe, [3] busy_res, [4] done_res, [5] ok,
    // [13:6] read_byte, [31:14] red_sample, [49:32] ir_sample, [55:50] zero
    output logic [i2csm_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [i2csm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import i2csm_pkg::*;

    logic [6:0]           device_address_reg;
    logic [7:0]           fifo_register_reg;

    phase_t               phase_reg, phase_next;
    logic [3:0]           bit_count_reg, bit_count_next;
    logic [2:0]           byte_count_reg, byte_count_next;
    logic [7:0]           shift_byte_reg, shift_byte_next;
    cmd_t                 command_kind_reg, command_kind_next;
    logic [7:0]           held_address_reg, held_address_next;
    logic [7:0]           held_data_reg, held_data_next;
    logic [CAPTURE_W-1:0] capture_reg, capture_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 oe_reg, oe_next;
    logic                 ok_reg, ok_next;
    logic [7:0]           last_read_reg, last_read_next;
    logic [SAMPLE_W-1:0]  red_reg, red_next;
    logic [SAMPLE_W-1:0]  ir_reg, ir_next;
    logic                 done_next;

    result_t              result_next;
    result_t              out_reg;
    result_t              skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;

    cmd_t                 opcode;
    logic [7:0]           reg_addr;
    logic [7:0]           write_data;
    logic                 sda_level;
    logic                 in_accept;
    logic                 tx_bit;
    logic                 mack_last;
    logic [7:0]           rx_byte;
    logic [3:0]           bit_count_inc;

    assign opcode     = cmd_t'(s_axis_tuser);
    assign reg_addr   = s_axis_tdata[7:0];
    assign write_data = s_axis_tdata[15:8];
    assign sda_level  = s_axis_tdata[16];

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign tx_bit        = shift_byte_reg[3'd7 - bit_count_reg[2:0]];
    assign rx_byte       = {shift_byte_reg[6:0], sda_level};
    assign bit_count_inc = bit_count_reg + 4'd1;
    assign mack_last     = (command_kind_reg != CMD_BURST)
                           || (byte_count_reg >= 3'(BURST_BYTES - 1));

    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        byte_count_next   = byte_count_reg;
        shift_byte_next   = shift_byte_reg;
        command_kind_next = command_kind_reg;
        held_address_next = held_address_reg;
        held_data_next    = held_data_reg;
        capture_next      = capture_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;
        oe_next           = oe_reg;
        ok_next           = ok_reg;
        last_read_next    = last_read_reg;
        red_next          = red_reg;
        ir_next           = ir_reg;
        done_next         = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (opcode != CMD_TICK)
                begin
                    command_kind_next = opcode;
                    held_address_next = (opcode == CMD_BURST) ? fifo_register_reg : reg_addr;
                    held_data_next    = write_data;
                    ok_next           = 1'b0;
                    if (opcode == CMD_BURST)
                    begin
                        capture_next = '0;
                    end
                    {scl_next, sda_next, oe_next} = 3'b101;
                    phase_next = PH_START_LOW;
                end
                else
                begin
                    {scl_next, sda_next, oe_next} = 3'b111;
                end
            end
            PH_START_LOW:
            begin
                {scl_next, sda_next, oe_next} = 3'b001;
                shift_byte_next = {device_address_reg, 1'b0};
                byte_count_next = STAGE_DEV_W;
                bit_count_next  = 4'd0;
                phase_next      = PH_TX_LOW;
            end
            PH_TX_LOW:
            begin
                {scl_next, sda_next, oe_next} = {1'b0, tx_bit, 1'b1};
                phase_next = PH_TX_HIGH;
            end
            PH_TX_HIGH:
            begin
                {scl_next, sda_next, oe_next} = {1'b1, tx_bit, 1'b1};
                bit_count_next = bit_count_inc;
                phase_next     = bit_count_inc[3] ? PH_ACK_LOW : PH_TX_LOW;
            end
            PH_ACK_LOW:
            begin
                {scl_next, sda_next, oe_next} = 3'b010;
                phase_next = PH_ACK_HIGH;
            end
            PH_ACK_HIGH:
            begin
                {scl_next, sda_next, oe_next} = 3'b110;
                priority if (sda_level)
                begin
                    ok_next    = 1'b0;
                    phase_next = PH_STOP_LOW;
                end
                else if (byte_count_reg == STAGE_DEV_W)
                begin
                    shift_byte_next = held_address_reg;
                    byte_count_next = STAGE_REG;
                    bit_count_next  = 4'd0;
                    phase_next      = PH_TX_LOW;
                end
                else if (byte_count_reg == STAGE_REG)
                begin
                    if (command_kind_reg == CMD_WRITE)
                    begin
                        shift_byte_next = held_data_reg;
                        byte_count_next = STAGE_DATA;
                        bit_count_next  = 4'd0;
                        phase_next      = PH_TX_LOW;
                    end
                    else
                    begin
                        phase_next = PH_RS_LOW;
                    end
                end
                else if (byte_count_reg == STAGE_DATA)
                begin
                    ok_next    = 1'b1;
                    phase_next = PH_STOP_LOW;
                end
                else
                begin
                    // read address acked: start receiving
                    byte_count_next = 3'd0;
                    bit_count_next  = 4'd0;
                    shift_byte_next = 8'd0;
                    phase_next      = PH_RX_LOW;
                end
            end
            PH_RS_LOW:
            begin
                {scl_next, sda_next, oe_next} = 3'b011;
                phase_next = PH_RS_HIGH;
            end
            PH_RS_HIGH:
            begin
                {scl_next, sda_next, oe_next} = 3'b111;
                phase_next = PH_RS_FALL;
            end
            PH_RS_FALL:
            begin
                {scl_next, sda_next, oe_next} = 3'b101;
                phase_next = PH_RS_CLAMP;
            end
            PH_RS_CLAMP:
            begin
                {scl_next, sda_next, oe_next} = 3'b001;
                shift_byte_next = {device_address_reg, 1'b1};
                byte_count_next = STAGE_DEV_R;
                bit_count_next  = 4'd0;
                phase_next      = PH_TX_LOW;
            end
            PH_RX_LOW:
            begin
                {scl_next, sda_next, oe_next} = 3'b010;
                phase_next = PH_RX_HIGH;
            end
            PH_RX_HIGH:
            begin
                {scl_next, sda_next, oe_next} = 3'b110;
                shift_byte_next = rx_byte;
                bit_count_next  = bit_count_inc;
                if (bit_count_inc[3])
                begin
                    if (command_kind_reg == CMD_READ)
                    begin
                        last_read_next = rx_byte;
                    end
                    else
                    begin
                        // first byte lands in the top of the capture word
                        for (int i = 0; i < CAPTURE_BYTES; i++)
                        begin
                            if (byte_count_reg == 3'(i))
                            begin
                                capture_next[(CAPTURE_BYTES-1-i)*8 +: 8] =
                                    capture_reg[(CAPTURE_BYTES-1-i)*8 +: 8] | rx_byte;
                            end
                        end
                    end
                    phase_next = PH_MACK_LOW;
                end
                else
                begin
                    phase_next = PH_RX_LOW;
                end
            end
            PH_MACK_LOW:
            begin
                {scl_next, sda_next, oe_next} = {1'b0, mack_last, 1'b1};
                phase_next = PH_MACK_HIGH;
            end
            PH_MACK_HIGH:
            begin
                {scl_next, sda_next, oe_next} = {1'b1, mack_last, 1'b1};
                if (mack_last)
                begin
                    ok_next    = 1'b1;
                    phase_next = PH_STOP_LOW;
                end
                else
                begin
                    byte_count_next = byte_count_reg + 3'd1;
                    bit_count_next  = 4'd0;
                    shift_byte_next = 8'd0;
                    phase_next      = PH_RX_LOW;
                end
            end
            PH_STOP_LOW:
            begin
                {scl_next, sda_next, oe_next} = 3'b001;
                phase_next = PH_STOP_HIGH;
            end
            PH_STOP_HIGH:
            begin
                {scl_next, sda_next, oe_next} = 3'b101;
                phase_next = PH_STOP_END;
            end
            PH_STOP_END:
            begin
                {scl_next, sda_next, oe_next} = 3'b111;
                done_next = 1'b1;
                if (command_kind_reg == CMD_BURST)
                begin
                    if (ok_reg)
                    begin
                        red_next = capture_reg[24 +: SAMPLE_W];
                        ir_next  = capture_reg[0 +: SAMPLE_W];
                    end
                    else
                    begin
                        red_next = '0;
                        ir_next  = '0;
                    end
                end
                phase_next = PH_IDLE;
            end
            default:
            begin
                {scl_next, sda_next, oe_next} = 3'b111;
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next.scl        = scl_next;
        result_next.sda_out    = oe_next ? sda_next : 1'b1;
        result_next.sda_oe     = oe_next;
        result_next.busy_res   = (phase_next != PH_IDLE);
        result_next.done_res   = done_next;
        result_next.ok         = ok_next;
        result_next.read_byte  = last_read_next;
        result_next.red_sample = red_next;
        result_next.ir_sample  = ir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= 7'd87;
            fifo_register_reg  <= 8'd7;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data[6:0];
                CFG_FIFO_REGISTER:  fifo_register_reg  <= cfg_data;
                default:            fifo_register_reg  <= fifo_register_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= 4'd0;
            byte_count_reg   <= 3'd0;
            shift_byte_reg   <= 8'd0;
            command_kind_reg <= CMD_TICK;
            held_address_reg <= 8'd0;
            held_data_reg    <= 8'd0;
            capture_reg      <= '0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
            oe_reg           <= 1'b1;
            ok_reg           <= 1'b0;
            last_read_reg    <= 8'd0;
            red_reg          <= '0;
            ir_reg           <= '0;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            byte_count_reg   <= byte_count_next;
            shift_byte_reg   <= shift_byte_next;
            command_kind_reg <= command_kind_next;
            held_address_reg <= held_address_next;
            held_data_reg    <= held_data_next;
            capture_reg      <= capture_next;
            scl_reg          <= scl_next;
            sda_reg          <= sda_next;
            oe_reg           <= oe_next;
            ok_reg           <= ok_next;
            last_read_reg    <= last_read_next;
            red_reg          <= red_next;
            ir_reg           <= ir_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_accept)
            begin
                out_reg <= result_next;
            end
        end
        else if (in_accept)
        begin
            skid_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_W - $bits(result_t))'(0), out_reg};

    // The skid entry only fills behind a stalled output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // A released data line must read back as high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.sda_oe) |-> out_reg.sda_out)
        else $error("released SDA not reported high");

    // A transaction in progress never returns to idle before its stop ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg != PH_IDLE && phase_reg != PH_STOP_END)
            |=> (phase_reg != PH_IDLE))
        else $error("transaction left busy state early");

    // The bit counter stops at eight.
    assert property (@(posedge clk) disable iff (!rst_n)
        !bit_count_reg[3] || (bit_count_reg[2:0] == 3'd0))
        else $error("bit counter overran a byte");

endmodule
